FILE: sv/averaged_power_hysteresis_switch_assert.svh
// Assertion helpers for the averaged power hysteresis switch.
`ifndef AVERAGED_POWER_HYSTERESIS_SWITCH_ASSERT_SVH
`define AVERAGED_POWER_HYSTERESIS_SWITCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APHS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aphs: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define APHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aphs: next-cycle check failed");

`endif

FILE: sv/aphs_pkg.sv
package aphs_pkg;

  // Window geometry
  localparam int WINDOW_LEN = 5;
  localparam int SAMPLE_W   = 21;
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int MAG_W      = SUM_W - 1;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
  localparam int AVG_W      = 21;

  // Reciprocal for the divide by WINDOW_LEN
  localparam int          DIV_SHIFT = MAG_W + $clog2(WINDOW_LEN);
  localparam int          MULT_W    = MAG_W + 1;
  localparam int          PROD_W    = MAG_W + MULT_W;
  localparam logic [63:0] DIV_MULT  =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);

  // Timing constants
  localparam logic [31:0] RETRY_MS      = 32'd5000;
  localparam logic [31:0] INTERVAL_DFLT = 32'd5000;
  localparam logic [31:0] INTERVAL_MAX  = 32'hFFFF_FFFF;

  // Register reset values
  localparam logic signed [20:0] ON_TH_RST  = -21'sd200;
  localparam logic signed [20:0] OFF_TH_RST = 21'sd200;

  // Configuration register indexes
  localparam logic [1:0] REG_ON_TH    = 2'd0;
  localparam logic [1:0] REG_OFF_TH   = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_HONOR    = 2'd3;

  typedef enum logic [2:0] {
    CMD_SAMPLE   = 3'd0,
    CMD_EVALUATE = 3'd1,
    CMD_DONE     = 3'd2,
    CMD_ENABLE   = 3'd3,
    CMD_DISABLE  = 3'd4,
    CMD_SHUTDOWN = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_UNDEF = 2'd0,
    ST_ON    = 2'd1,
    ST_OFF   = 2'd2
  } confirm_t;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_IMMEDIATE = 2'd1,
    MODE_NEVER     = 2'd2
  } mode_t;

  // Sign-extend a sample to the running sum width
  function automatic logic signed [SUM_W-1:0] sext_sum(input logic [SAMPLE_W-1:0] s);
    return {{(SUM_W - SAMPLE_W){s[SAMPLE_W-1]}}, s};
  endfunction

  // Window sum divided by WINDOW_LEN, truncated toward zero
  function automatic logic signed [AVG_W-1:0] div_window(input logic signed [SUM_W-1:0] sum);
    logic              neg;
    logic [SUM_W-1:0]  mag_full;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [AVG_W-1:0]  quo;
    neg      = sum[SUM_W-1];
    mag_full = neg ? (~sum + 1'b1) : sum;
    mag      = mag_full[MAG_W-1:0];
    prod     = PROD_W'(mag) * PROD_W'(DIV_MULT[MULT_W-1:0]);
    quo      = AVG_W'(prod >> DIV_SHIFT);
    return neg ? (~quo + 1'b1) : quo;
  endfunction

endpackage

FILE: sv/averaged_power_hysteresis_switch.sv
// Averaged power hysteresis switch.
// Input channel (s_*): one transaction per command; s_tuser carries the
// command, s_tdata the meter values, time stamp and request result.
// Output channel (m_*): exactly one result transaction per input transaction,
// in order, with the request flags, confirmed state, window average and
// window-full flag.
// Configuration channel (cfg_*): always ready; writes thresholds, switch
// interval and the result-honor flag; write only while the block is idle.
// A result passes through the middle stage and then the output register.
// Throughput: one transaction per cycle while the receiver keeps up; the state
// update for an item is done in the cycle it is accepted, the average divide
// sits in the second register stage.
// Reset clears the sample window, returns registers to their defaults and
// leaves the block disabled with the confirmed state undefined.
// When the receiver stalls, the output register holds, the middle stage
// fills, and s_tready drops once both stages are occupied.
`include "averaged_power_hysteresis_switch_assert.svh"

module averaged_power_hysteresis_switch
  import aphs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [19:0] import_w, [39:20] export_w, [71:40] now_ms, [72] request_ok
  input  logic [79:0] s_tdata,
  // [2:0] command
  input  logic [2:0]  s_tuser,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] request_valid, [1] request_on, [3:2] confirmed_state,
  // [24:4] average_w, [25] window_full
  output logic [31:0] m_tdata,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic signed [20:0] on_threshold_w;
  logic signed [20:0] off_threshold_w;
  logic [31:0]        switch_interval_ms;
  logic               honor_result;

  // Block state
  logic [SAMPLE_W-1:0]     sample_window [WINDOW_LEN];
  logic [SAMPLE_W-1:0]     sample_window_next [WINDOW_LEN];
  logic signed [SUM_W-1:0] window_sum, window_sum_next;
  logic [FILL_W-1:0]       fill_count, fill_count_next;
  confirm_t                last_state, last_state_next;
  logic [31:0]             last_switch_ms, last_switch_ms_next;
  logic                    is_enabled, is_enabled_next;
  logic                    shutting_down, shutting_down_next;
  mode_t                   interval_mode, interval_mode_next;
  logic                    request_pending, request_pending_next;
  logic                    pending_on, pending_on_next;

  // Middle stage
  logic                    p_valid;
  logic                    p_req_valid;
  logic                    p_req_on;
  confirm_t                p_state;
  logic signed [SUM_W-1:0] p_sum;
  logic                    p_full;

  // Output stage
  logic                    o_req_valid;
  logic                    o_req_on;
  confirm_t                o_state;
  logic signed [AVG_W-1:0] o_avg;
  logic                    o_full;

  // Item decode
  logic                 s_accept;
  cmd_t                 cmd;
  logic [19:0]          import_w;
  logic [19:0]          export_w;
  logic [31:0]          now_ms;
  logic                 request_ok;
  logic [SAMPLE_W-1:0]  sample_w;
  logic                 full_now;
  logic signed [AVG_W-1:0] avg_now;
  logic [31:0]          eff_interval;
  logic [31:0]          elapsed_ms;
  logic                 issue_try;
  logic                 issue_want;
  logic                 want_on;
  logic                 issue_fire;
  logic                 issue_on;
  logic                 advance_o;

  assign cmd        = cmd_t'(s_tuser);
  assign import_w   = s_tdata[19:0];
  assign export_w   = s_tdata[39:20];
  assign now_ms     = s_tdata[71:40];
  assign request_ok = s_tdata[72];

  // Handshake chain
  assign advance_o = !m_tvalid || m_tready;
  assign s_tready  = !p_valid || advance_o;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Current window view
  assign sample_w   = {1'b0, import_w} - {1'b0, export_w};
  assign full_now   = (fill_count == FILL_W'(WINDOW_LEN));
  assign avg_now    = div_window(window_sum);
  assign elapsed_ms = now_ms - last_switch_ms;

  // Pick the interval the current mode imposes
  always_comb begin
    case (interval_mode)
      MODE_IMMEDIATE: eff_interval = 32'd0;
      MODE_NEVER:     eff_interval = INTERVAL_MAX;
      default:        eff_interval = switch_interval_ms;
    endcase
  end

  // Apply one item to the state
  always_comb begin
    sample_window_next   = sample_window;
    window_sum_next      = window_sum;
    fill_count_next      = fill_count;
    last_state_next      = last_state;
    last_switch_ms_next  = last_switch_ms;
    is_enabled_next      = is_enabled;
    shutting_down_next   = shutting_down;
    interval_mode_next   = interval_mode;
    request_pending_next = request_pending;
    pending_on_next      = pending_on;
    issue_try            = 1'b0;
    issue_want           = 1'b0;
    want_on              = 1'b0;
    issue_fire           = 1'b0;
    issue_on             = 1'b0;

    if (s_accept) begin
      unique case (cmd)
        CMD_SAMPLE: begin
          if (is_enabled) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
              sample_window_next[i] = sample_window[i+1];
            end
            sample_window_next[WINDOW_LEN-1] = sample_w;
            window_sum_next = window_sum - sext_sum(sample_window[0]) + sext_sum(sample_w);
            if (!full_now) begin
              fill_count_next = fill_count + 1'b1;
            end
          end
        end
        CMD_EVALUATE: begin
          if (is_enabled && !(shutting_down && interval_mode == MODE_NEVER) &&
              elapsed_ms >= eff_interval) begin
            issue_try = 1'b1;
            issue_want = (last_state == ST_ON);
            if (full_now) begin
              if (avg_now < on_threshold_w) begin
                issue_want = 1'b1;
              end
              if (off_threshold_w < avg_now) begin
                issue_want = 1'b0;
              end
            end
          end
        end
        CMD_DONE: begin
          if (request_pending) begin
            request_pending_next = 1'b0;
            if (request_ok || !honor_result) begin
              last_switch_ms_next = now_ms;
              last_state_next     = pending_on ? ST_ON : ST_OFF;
            end else begin
              last_switch_ms_next = now_ms + RETRY_MS - eff_interval;
            end
          end
        end
        CMD_ENABLE: begin
          if (!is_enabled) begin
            last_switch_ms_next = now_ms - eff_interval;
            is_enabled_next     = 1'b1;
          end
        end
        CMD_DISABLE: begin
          if (is_enabled) begin
            issue_try       = 1'b1;
            is_enabled_next = 1'b0;
          end
        end
        CMD_SHUTDOWN: begin
          if (is_enabled) begin
            shutting_down_next = 1'b1;
            if (last_state == ST_OFF) begin
              interval_mode_next = MODE_NEVER;
            end else begin
              last_state_next    = ST_UNDEF;
              interval_mode_next = MODE_IMMEDIATE;
              for (int i = 0; i < WINDOW_LEN; i++) begin
                sample_window_next[i] = '0;
              end
              window_sum_next = '0;
              fill_count_next = '0;
              issue_try       = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Issue a request unless already confirmed or one is outstanding
    if (issue_try) begin
      want_on = issue_want && !shutting_down_next;
      if (last_state_next != (want_on ? ST_ON : ST_OFF) && !request_pending) begin
        request_pending_next = 1'b1;
        pending_on_next      = want_on;
        issue_fire           = 1'b1;
        issue_on             = want_on;
      end
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      on_threshold_w     <= ON_TH_RST;
      off_threshold_w    <= OFF_TH_RST;
      switch_interval_ms <= INTERVAL_DFLT;
      honor_result       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ON_TH:    on_threshold_w  <= cfg_data[20:0];
        REG_OFF_TH:   off_threshold_w <= cfg_data[20:0];
        REG_INTERVAL: switch_interval_ms <= (cfg_data == 32'd0) ? INTERVAL_DFLT : cfg_data;
        REG_HONOR:    honor_result    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Update block state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        sample_window[i] <= '0;
      end
      window_sum      <= '0;
      fill_count      <= '0;
      last_state      <= ST_UNDEF;
      last_switch_ms  <= '0;
      is_enabled      <= 1'b0;
      shutting_down   <= 1'b0;
      interval_mode   <= MODE_NORMAL;
      request_pending <= 1'b0;
      pending_on      <= 1'b0;
    end else begin
      sample_window   <= sample_window_next;
      window_sum      <= window_sum_next;
      fill_count      <= fill_count_next;
      last_state      <= last_state_next;
      last_switch_ms  <= last_switch_ms_next;
      is_enabled      <= is_enabled_next;
      shutting_down   <= shutting_down_next;
      interval_mode   <= interval_mode_next;
      request_pending <= request_pending_next;
      pending_on      <= pending_on_next;
    end
  end

  // Middle stage: capture request flags and the post-item window
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_tready) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      p_req_valid <= issue_fire;
      p_req_on    <= issue_on;
      p_state     <= last_state_next;
      p_sum       <= window_sum_next;
      p_full      <= (fill_count_next == FILL_W'(WINDOW_LEN));
    end
  end

  // Output stage: divide the window sum once the window is full and present the result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance_o) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_o && p_valid) begin
      o_req_valid <= p_req_valid;
      o_req_on    <= p_req_on;
      o_state     <= p_state;
      o_avg       <= p_full ? div_window(p_sum) : '0;
      o_full      <= p_full;
    end
  end

  assign m_tdata = {6'd0, o_full, o_avg, o_state, o_req_on, o_req_valid};

  // Checks
  `APHS_ASSERT_SAME(a_req_on_needs_valid, m_tvalid && o_req_on, o_req_valid)
  `APHS_ASSERT_NEXT(a_issue_sets_pending, issue_fire, request_pending)
  `APHS_ASSERT_NEXT(a_idle_sample_keeps_sum,
                    s_accept && cmd == CMD_SAMPLE && !is_enabled, $stable(window_sum))
  `APHS_ASSERT_SAME(a_fill_bounded, s_accept, fill_count <= FILL_W'(WINDOW_LEN))

endmodule

FILE: bench/tb_averaged_power_hysteresis_switch.sv
`default_nettype none

module tb_averaged_power_hysteresis_switch
  import aphs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Commands the block does not decode; they must pass through untouched
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic                req_valid;
    logic                req_on;
    confirm_t            confirmed;
    logic [AVG_W-1:0]    avg;
    logic                full;
  } status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Switch state as it should be inside the block
  logic signed [20:0]         on_th = ON_TH_RST;
  logic signed [20:0]         off_th = OFF_TH_RST;
  logic [31:0]                interval_ms = INTERVAL_DFLT;
  logic                       honor = 1'b1;
  logic signed [SAMPLE_W-1:0] net_window [WINDOW_LEN] = '{default: '0};
  logic signed [SUM_W-1:0]    window_sum = '0;
  logic [FILL_W-1:0]          fill = '0;
  confirm_t                   last_st = ST_UNDEF;
  logic [31:0]                last_sw = '0;
  logic                       enabled = 1'b0;
  logic                       shutting = 1'b0;
  logic                       pend = 1'b0;
  logic                       pend_on = 1'b0;
  mode_t                      mode = MODE_NORMAL;

  status_t status_due [$];
  int      fail_count = 0;

  // Stimulus shaping
  bit          feed_enabled = 1'b0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int          rx_hold_len = 0;
  int          rx_wait = 0;
  logic [31:0] stim_ms = 32'd50000;
  int          ms_step = 2000;
  int          sample_span = 2000;

  averaged_power_hysteresis_switch uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] effective_interval();
    case (mode)
      MODE_IMMEDIATE: return '0;
      MODE_NEVER:     return INTERVAL_MAX;
      default:        return interval_ms;
    endcase
  endfunction

  // Issue a request unless the state is already confirmed or one is in flight
  function automatic void issue_request(input logic want_on, inout status_t r);
    if (shutting) want_on = 1'b0;
    if (last_st == (want_on ? ST_ON : ST_OFF) || pend) return;
    pend = 1'b1;
    pend_on = want_on;
    r.req_valid = 1'b1;
    r.req_on = want_on;
  endfunction

  // Advance the switch state by one command and return the status it reports
  function automatic status_t apply_command(input logic [2:0] cmd, input logic [79:0] d);
    logic [19:0]        imp;
    logic [19:0]        exp_w;
    logic [31:0]        now;
    logic               ok;
    logic signed [20:0] net;
    logic               want_on;
    logic               full;
    int                 avg;
    status_t            r;
    imp = d[19:0];
    exp_w = d[39:20];
    now = d[71:40];
    ok = d[72];
    r = '0;
    full = (fill >= WINDOW_LEN);
    avg = full ? int'(window_sum) / WINDOW_LEN : 0;
    case (cmd)
      CMD_SAMPLE: begin
        if (enabled) begin
          net = $signed({1'b0, imp}) - $signed({1'b0, exp_w});
          window_sum = window_sum - net_window[0] + net;
          for (int i = 1; i < WINDOW_LEN; i++) net_window[i-1] = net_window[i];
          net_window[WINDOW_LEN-1] = net;
          if (fill < WINDOW_LEN) fill = fill + 1'b1;
        end
      end
      CMD_EVALUATE: begin
        if (enabled && !(shutting && mode == MODE_NEVER) &&
            (now - last_sw) >= effective_interval()) begin
          want_on = (last_st == ST_ON);
          if (full) begin
            if (avg < on_th) want_on = 1'b1;
            if (off_th < avg) want_on = 1'b0;
          end
          issue_request(want_on, r);
        end
      end
      CMD_DONE: begin
        if (pend) begin
          pend = 1'b0;
          last_sw = now;
          if (ok || !honor) last_st = pend_on ? ST_ON : ST_OFF;
          else last_sw = last_sw + RETRY_MS - effective_interval();
        end
      end
      CMD_ENABLE: begin
        if (!enabled) begin
          last_sw = now - effective_interval();
          enabled = 1'b1;
        end
      end
      CMD_DISABLE: begin
        if (enabled) begin
          issue_request(1'b0, r);
          enabled = 1'b0;
        end
      end
      CMD_SHUTDOWN: begin
        if (enabled) begin
          shutting = 1'b1;
          if (last_st == ST_OFF) begin
            mode = MODE_NEVER;
          end else begin
            last_st = ST_UNDEF;
            mode = MODE_IMMEDIATE;
            for (int i = 0; i < WINDOW_LEN; i++) net_window[i] = '0;
            window_sum = '0;
            fill = '0;
            issue_request(1'b0, r);
          end
        end
      end
      default: ;
    endcase
    full = (fill >= WINDOW_LEN);
    r.confirmed = last_st;
    r.full = full;
    r.avg = full ? AVG_W'(int'(window_sum) / WINDOW_LEN) : '0;
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $time);
    fail_count++;
  endtask

  // Track register writes and input transactions, check each result transaction
  always @(posedge clk) begin : track_and_check
    status_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ON_TH:    on_th = cfg_data[20:0];
          REG_OFF_TH:   off_th = cfg_data[20:0];
          REG_INTERVAL: interval_ms = (cfg_data == '0) ? INTERVAL_DFLT : cfg_data;
          REG_HONOR:    honor = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) status_due.push_back(apply_command(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (status_due.size() == 0) begin
          flag_mismatch("result with none due", m_tdata, '0);
        end else begin
          want = status_due.pop_front();
          if (m_tdata[0] !== want.req_valid)
            flag_mismatch("request_valid", 32'(m_tdata[0]), 32'(want.req_valid));
          if (m_tdata[1] !== want.req_on)
            flag_mismatch("request_on", 32'(m_tdata[1]), 32'(want.req_on));
          if (m_tdata[3:2] !== want.confirmed)
            flag_mismatch("confirmed_state", 32'(m_tdata[3:2]), 32'(want.confirmed));
          if (m_tdata[24:4] !== want.avg)
            flag_mismatch("average_w", 32'(m_tdata[24:4]), 32'(want.avg));
          if (m_tdata[25] !== want.full)
            flag_mismatch("window_full", 32'(m_tdata[25]), 32'(want.full));
          if (m_tdata[31:26] !== '0)
            flag_mismatch("padding", 32'(m_tdata[31:26]), '0);
        end
      end
    end
  end

  // Pace the receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin : rx_pacing
    int stall;
    stall = 0;
    if (rx_hold_len != 0) begin
      rx_wait = rx_hold_len;
      rx_hold_len = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      if (rx_gaps_on) stall = pick_gap();
      if (stall != 0) begin
        rx_wait = stall - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one command and hold it until the block takes the transaction
  task automatic send_item(input logic [2:0] cmd, input logic [19:0] imp,
                           input logic [19:0] exp_w, input logic [31:0] now,
                           input logic ok);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {7'd0, ok, now, exp_w, imp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_ENABLE) feed_enabled = 1'b1;
    if (cmd == CMD_DISABLE) feed_enabled = 1'b0;
  endtask

  // Stop offering and wait until every result is back and the pipe is empty
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Program all four registers once the block is idle; junk in unused bits
  task automatic set_registers(input int on_w, input int off_w,
                               input logic [31:0] interval, input bit hon);
    logic [10:0] junk_lo;
    logic [30:0] junk_hi;
    wait_drained();
    junk_lo = 11'($urandom);
    write_reg(REG_ON_TH, {junk_lo, on_w[20:0]});
    junk_lo = 11'($urandom);
    write_reg(REG_OFF_TH, {junk_lo, off_w[20:0]});
    write_reg(REG_INTERVAL, interval);
    junk_hi = 31'($urandom);
    write_reg(REG_HONOR, {junk_hi, hon});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly enabled traffic: samples, evaluates usually followed by completion
  task automatic send_random_items(input int count, input bit allow_shutdown);
    int          pick;
    logic [2:0]  cmd;
    logic [19:0] imp;
    logic [19:0] exp_w;
    logic [31:0] now;
    logic        ok;
    bit          chain_done;
    chain_done = 1'b0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (chain_done) cmd = CMD_DONE;
      else if (!feed_enabled) begin
        if (pick < 85) cmd = CMD_ENABLE;
        else if (pick < 89) cmd = CMD_SAMPLE;
        else if (pick < 93) cmd = CMD_EVALUATE;
        else if (pick < 96) cmd = CMD_DONE;
        else if (pick < 98) cmd = CMD_SHUTDOWN;
        else cmd = CMD_SPARE7;
      end else begin
        if (pick < 48) cmd = CMD_SAMPLE;
        else if (pick < 74) cmd = CMD_EVALUATE;
        else if (pick < 82) cmd = CMD_DONE;
        else if (pick < 85) cmd = CMD_ENABLE;
        else if (pick < 90) cmd = CMD_DISABLE;
        else if (pick < 92) cmd = allow_shutdown ? CMD_SHUTDOWN : CMD_SAMPLE;
        else if (pick < 96) cmd = CMD_SAMPLE;
        else if (pick < 98) cmd = CMD_SPARE6;
        else cmd = CMD_SPARE7;
      end
      imp = 20'($urandom_range(0, 20'hFFFFF));
      exp_w = 20'($urandom_range(0, 20'hFFFFF));
      if (cmd == CMD_SAMPLE && $urandom_range(0, 99) < 85) begin
        imp = 20'($urandom_range(0, sample_span));
        exp_w = 20'($urandom_range(0, sample_span));
      end
      now = $urandom;
      if ((cmd == CMD_EVALUATE || cmd == CMD_DONE || cmd == CMD_ENABLE) &&
          $urandom_range(0, 99) >= 3) begin
        stim_ms = stim_ms + $urandom_range(0, ms_step);
        now = stim_ms;
      end
      ok = ($urandom_range(0, 9) < 7);
      send_item(cmd, imp, exp_w, now, ok);
      chain_done = (cmd == CMD_EVALUATE) && ($urandom_range(0, 9) < 6);
    end
  endtask

  // Disabled block after reset: everything is ignored
  task automatic test_idle_block();
    send_item(CMD_SAMPLE, 20'hFFFFF, 20'h00000, 32'd0, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, 32'd100000, 1'b0);
    send_item(CMD_DONE, '0, '0, 32'd100, 1'b1);
    send_item(CMD_DISABLE, '0, '0, '0, 1'b0);
    send_item(CMD_SHUTDOWN, '0, '0, '0, 1'b0);
    send_item(CMD_SPARE6, 20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_SPARE7, '0, '0, '0, 1'b0);
  endtask

  // Walk through window fill, both switch directions, retry and disable
  task automatic test_directed_switching();
    send_item(CMD_ENABLE, '0, '0, 32'd1000, 1'b0);
    // window empty: ask for off from undefined
    send_item(CMD_EVALUATE, '0, '0, 32'd1000, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, 32'd1001, 1'b0);
    send_item(CMD_DONE, '0, '0, 32'd1002, 1'b1);
    // extreme samples, ending with a full window of maximum export
    send_item(CMD_SAMPLE, 20'hFFFFF, 20'h00000, '0, 1'b0);
    repeat (WINDOW_LEN) send_item(CMD_SAMPLE, 20'h00000, 20'hFFFFF, '0, 1'b0);
    // one short of the interval, then exactly on it
    send_item(CMD_EVALUATE, '0, '0, 32'd6001, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, 32'd6002, 1'b0);
    // failed request: retry only after the retry delay
    send_item(CMD_DONE, '0, '0, 32'd6010, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, 32'd11009, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, 32'd11010, 1'b0);
    send_item(CMD_DONE, '0, '0, 32'd11020, 1'b1);
    // maximum import pushes the average above the off threshold
    repeat (WINDOW_LEN) send_item(CMD_SAMPLE, 20'hFFFFF, 20'h00000, '0, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, 32'd16020, 1'b0);
    // disable with a request in flight, complete it while disabled
    send_item(CMD_DISABLE, '0, '0, '0, 1'b0);
    send_item(CMD_DONE, '0, '0, 32'd16030, 1'b1);
    send_item(CMD_ENABLE, '0, '0, 32'd20000, 1'b0);
  endtask

  // Several register settings, the extremes and swapped thresholds among them
  task automatic test_register_settings();
    set_registers(-1048576, 1048575, 32'd1, 1'b0);
    send_random_items(60, 1'b0);
    set_registers(1048575, -1048576, 32'd0, 1'b1);
    send_random_items(60, 1'b0);
    set_registers(500, -500, 32'd2000, 1'b1);
    send_random_items(60, 1'b0);
    set_registers(-300, 300, 32'hFFFF_FFFF, 1'b1);
    send_random_items(60, 1'b0);
    set_registers(-150, 150, 32'd700, 1'b0);
    send_random_items(60, 1'b0);
    set_registers(0, 0, 32'd3000, 1'b1);
    send_random_items(60, 1'b0);
  endtask

  // Random phases with random settings; one wraps the clock, one runs with no idling
  task automatic test_random_traffic();
    int          on_w;
    int          off_w;
    logic [31:0] interval;
    int          r;
    for (int p = 0; p < 8; p++) begin
      on_w = -int'($urandom_range(0, 1500));
      off_w = $urandom_range(0, 1500);
      if ($urandom_range(0, 9) == 0) on_w = $urandom;
      if ($urandom_range(0, 9) == 0) off_w = $urandom;
      r = $urandom_range(0, 9);
      interval = (r == 0) ? 32'd0 : (r == 1) ? 32'($urandom) : $urandom_range(1, 6000);
      set_registers(on_w, off_w, interval, 1'($urandom_range(0, 1)));
      ms_step = $urandom_range(100, 4000);
      sample_span = $urandom_range(200, 5000);
      if (p == 3) stim_ms = 32'hFFFF_E000;
      tx_gaps_on = (p != 5);
      rx_gaps_on = (p != 5);
      send_random_items(100, 1'b0);
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Hold the receiver off while the sender floods, then pause until drained
  task automatic test_backpressure();
    wait_drained();
    tx_gaps_on = 1'b0;
    rx_hold_len = 300;
    send_random_items(40, 1'b0);
    wait_drained();
    tx_gaps_on = 1'b1;
    send_random_items(20, 1'b0);
  endtask

  // Shutdown from on (immediate off, forced off retry), then from off (frozen)
  task automatic test_shutdown();
    set_registers(-200, 200, 32'd1000, 1'b1);
    stim_ms = stim_ms + 32'd100000;
    send_item(CMD_ENABLE, '0, '0, stim_ms, 1'b0);
    send_item(CMD_DONE, '0, '0, stim_ms, 1'b1);
    repeat (WINDOW_LEN) send_item(CMD_SAMPLE, 20'd0, 20'd5000, '0, 1'b0);
    stim_ms = stim_ms + 32'd1000000;
    send_item(CMD_EVALUATE, '0, '0, stim_ms, 1'b0);
    send_item(CMD_DONE, '0, '0, stim_ms + 32'd1, 1'b1);
    send_item(CMD_SHUTDOWN, '0, '0, '0, 1'b0);
    repeat (2) send_item(CMD_SAMPLE, 20'd0, 20'd5000, '0, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, stim_ms + 32'd2, 1'b0);
    send_item(CMD_DONE, '0, '0, stim_ms + 32'd3, 1'b0);
    repeat (WINDOW_LEN) send_item(CMD_SAMPLE, 20'd0, 20'd5000, '0, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, stim_ms + 32'd4, 1'b0);
    send_item(CMD_DONE, '0, '0, stim_ms + 32'd5, 1'b1);
    send_item(CMD_SHUTDOWN, '0, '0, '0, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, stim_ms + 32'h8000_0000, 1'b0);
    send_item(CMD_DISABLE, '0, '0, '0, 1'b0);
    send_item(CMD_ENABLE, '0, '0, stim_ms + 32'd10, 1'b0);
    send_item(CMD_EVALUATE, '0, '0, stim_ms + 32'd10, 1'b0);
    send_random_items(60, 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_idle_block();
    test_directed_switching();
    test_register_settings();
    test_random_traffic();
    test_backpressure();
    test_shutdown();
    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("averaged_power_hysteresis_switch regression: pass");
    end else begin
      $display("averaged_power_hysteresis_switch regression: fail");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #10_000_000;
    $display("averaged_power_hysteresis_switch regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
